@@ hdl/assert_macros.svh @@
// shared assertion macros, clocked on clk with async active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/hcbd_pkg.sv @@
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int LEN_BITS = 32;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    typedef enum logic [7:0] {
        PH_SIZE     = 8'b0000_0001,
        PH_DATA     = 8'b0000_0010,
        PH_CHUNK_CR = 8'b0000_0100,
        PH_CHUNK_LF = 8'b0000_1000,
        PH_FINAL_CR = 8'b0001_0000,
        PH_FINAL_LF = 8'b0010_0000,
        PH_DONE     = 8'b0100_0000,
        PH_ERROR    = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_EMPTY_SIZE = 3'd1,
        ERR_BAD_CHAR   = 3'd2,
        ERR_OVERFLOW   = 3'd3,
        ERR_CHUNK_END  = 3'd4,
        ERR_FINAL_END  = 3'd5,
        ERR_TRUNCATED  = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
        logic       first_of_body;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [1:0] status;
        logic [2:0] error_kind;
    } out_item_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            h.value = 4'(c - "0");
        end
        else if (c >= "A" && c <= "F")
        begin
            h.value = 4'(c - "A" + 8'd10);
        end
        else if (c >= "a" && c <= "f")
        begin
            h.value = 4'(c - "a" + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ hdl/hcbd_if.sv @@
`timescale 1ns / 1ps

interface hcbd_in_if import hcbd_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcbd_out_if import hcbd_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/http_chunked_body_decoder.sv @@
`timescale 1ns / 1ps
// registered: the result of an accepted byte is presented in the cycle after it is taken
// throughput: one byte per cycle unless the output stalls; the decode is a single pass into the result register
// a new byte is taken whenever the result register is empty or being drained
// reset: rst_n async low; decoder returns to the size line phase, result register empties

module http_chunked_body_decoder import hcbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hcbd_in_if.sink      in_ch,
    hcbd_out_if.source   out_ch
);

    phase_t              phase_reg,   phase_next;
    logic [LEN_BITS-1:0] len_reg,     len_next;
    logic                seen_reg,    seen_next;
    err_t                err_reg,     err_next;
    logic                out_valid_reg;
    out_item_t           out_data_reg, out_data_next;

    logic     accept;
    phase_t   ph;
    hex_t     hex;
    logic [7:0] c;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign c   = in_ch.data.data_byte;
    assign hex = hex_decode(c);

    always_comb
    begin
        ph        = in_ch.data.first_of_body ? PH_SIZE : phase_reg;
        len_next  = in_ch.data.first_of_body ? '0 : len_reg;
        seen_next = in_ch.data.first_of_body ? 1'b0 : seen_reg;
        err_next  = in_ch.data.first_of_body ? ERR_NONE : err_reg;
        phase_next = ph;
        out_data_next.payload_byte  = 8'd0;
        out_data_next.payload_valid = 1'b0;

        if (ph == PH_DONE || ph == PH_ERROR)
        begin
            phase_next = ph;
        end
        else if (in_ch.data.end_of_input)
        begin
            phase_next = PH_ERROR;
            err_next   = ERR_TRUNCATED;
        end
        else
        begin
            case (ph)
                PH_SIZE:
                begin
                    if (c == CH_CR)
                    begin
                        phase_next = PH_SIZE;
                    end
                    else if (c == CH_LF)
                    begin
                        if (!seen_next)
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_EMPTY_SIZE;
                        end
                        else
                        begin
                            phase_next = (len_next == '0) ? PH_FINAL_CR : PH_DATA;
                            seen_next  = 1'b0;
                        end
                    end
                    else if (!hex.ok)
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ERR_BAD_CHAR;
                    end
                    else if (len_next[LEN_BITS-1 -: 4] != 4'd0)
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ERR_OVERFLOW;
                    end
                    else
                    begin
                        len_next  = {len_next[LEN_BITS-5:0], hex.value};
                        seen_next = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    out_data_next.payload_byte  = c;
                    out_data_next.payload_valid = 1'b1;
                    len_next = len_next - LEN_BITS'(1);
                    if (len_next == '0)
                    begin
                        phase_next = PH_CHUNK_CR;
                    end
                end
                PH_CHUNK_CR:
                begin
                    if (c == CH_CR)
                    begin
                        phase_next = PH_CHUNK_LF;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ERR_CHUNK_END;
                    end
                end
                PH_CHUNK_LF:
                begin
                    if (c == CH_LF)
                    begin
                        phase_next = PH_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ERR_CHUNK_END;
                    end
                end
                PH_FINAL_CR:
                begin
                    if (c == CH_CR)
                    begin
                        phase_next = PH_FINAL_LF;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ERR_FINAL_END;
                    end
                end
                default:
                begin
                    if (c == CH_LF)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        err_next   = ERR_FINAL_END;
                    end
                end
            endcase
        end

        if (phase_next == PH_DONE)
        begin
            out_data_next.status = ST_DONE;
        end
        else if (phase_next == PH_ERROR)
        begin
            out_data_next.status = ST_ERROR;
        end
        else
        begin
            out_data_next.status = ST_BUSY;
        end
        out_data_next.error_kind = (phase_next == PH_ERROR) ? err_next : ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            len_reg       <= '0;
            seen_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                seen_reg  <= seen_next;
                err_reg   <= err_next;
            end
            if (in_ch.ready)
            begin
                out_valid_reg <= in_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ hdl/hcbd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcbd_checker import hcbd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    `ASSERT_NOW(a_payload_only_busy, out_valid && out_data.payload_valid,
                out_data.status == ST_BUSY)
    `ASSERT_NOW(a_error_has_kind, out_valid && out_data.status == ST_ERROR,
                out_data.error_kind != ERR_NONE)
    `ASSERT_NOW(a_kind_only_on_error, out_valid && out_data.status != ST_ERROR,
                out_data.error_kind == ERR_NONE)
    `ASSERT_NOW(a_idle_byte_zero, out_valid && !out_data.payload_valid,
                out_data.payload_byte == 8'd0)
    `ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
